FILE: rtl/core/tzt_pkg.sv
// ----------------------------------------------------------------------------
// tzt_pkg
// Shared types, codes and helpers of the threshold zone tracker.
// ----------------------------------------------------------------------------
package tzt_pkg;

   // Configuration port widths
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_UPPER_NC   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_UPPER_C    = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_UPPER_NR   = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWER_NC   = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWER_C    = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWER_NR   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RISING_OFS = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FALLING_OFS = 4'd7;

   // Reading held after reset
   localparam logic signed [7:0] READING_RESET = 8'sd16;

   // Zone codes as reported on the result word
   localparam logic [2:0] ZONE_NORMAL   = 3'd0;
   localparam logic [2:0] ZONE_ABOVE_NC = 3'd1;
   localparam logic [2:0] ZONE_ABOVE_C  = 3'd2;
   localparam logic [2:0] ZONE_ABOVE_NR = 3'd3;
   localparam logic [2:0] ZONE_BELOW_NC = 3'd4;
   localparam logic [2:0] ZONE_BELOW_C  = 3'd5;
   localparam logic [2:0] ZONE_BELOW_NR = 3'd6;

   // Event codes
   localparam logic [3:0] EV_NONE         = 4'd0;
   localparam logic [3:0] EV_UNC_HIGH     = 4'd0;
   localparam logic [3:0] EV_UNC_LOW      = 4'd1;
   localparam logic [3:0] EV_UC_HIGH      = 4'd2;
   localparam logic [3:0] EV_UC_LOW       = 4'd3;
   localparam logic [3:0] EV_UNR_HIGH     = 4'd4;
   localparam logic [3:0] EV_UNR_LOW      = 4'd5;
   localparam logic [3:0] EV_LNC_LOW      = 4'd6;
   localparam logic [3:0] EV_LNC_HIGH     = 4'd7;
   localparam logic [3:0] EV_LC_LOW       = 4'd8;
   localparam logic [3:0] EV_LC_HIGH      = 4'd9;
   localparam logic [3:0] EV_LNR_LOW      = 4'd10;
   localparam logic [3:0] EV_LNR_HIGH     = 4'd11;

   // Tracker state, one bit per zone
   typedef enum logic [6:0] {
      ST_NORMAL   = 7'b0000001,
      ST_ABOVE_NC = 7'b0000010,
      ST_ABOVE_C  = 7'b0000100,
      ST_ABOVE_NR = 7'b0001000,
      ST_BELOW_NC = 7'b0010000,
      ST_BELOW_C  = 7'b0100000,
      ST_BELOW_NR = 7'b1000000
   } zone_state_type;

   // Input word
   typedef struct packed {
      logic [7:0]        sensor_select;
      logic signed [7:0] temperature;
   } req_payload_type;

   // Result word
   typedef struct packed {
      logic [2:0]        zone;
      logic              event_valid;
      logic [3:0]        event_code;
      logic signed [7:0] last_reading;
   } rsp_payload_type;

   // Sample at or above threshold plus offset; 9-bit sum cannot overflow
   function automatic logic at_or_above(logic [7:0] t, logic [7:0] thr,
                                        logic [7:0] ofs);
      logic signed [8:0] lim;
      logic signed [8:0] smp;
      lim = {thr[7], thr} + {ofs[7], ofs};
      smp = {t[7], t};
      return smp >= lim;
   endfunction

   // Sample at or below threshold plus offset
   function automatic logic at_or_below(logic [7:0] t, logic [7:0] thr,
                                        logic [7:0] ofs);
      logic signed [8:0] lim;
      logic signed [8:0] smp;
      lim = {thr[7], thr} + {ofs[7], ofs};
      smp = {t[7], t};
      return smp <= lim;
   endfunction

   // Map tracker state to its reported zone code
   function automatic logic [2:0] zone_code(zone_state_type z);
      logic [2:0] code;
      case (z)
         ST_NORMAL:   code = ZONE_NORMAL;
         ST_ABOVE_NC: code = ZONE_ABOVE_NC;
         ST_ABOVE_C:  code = ZONE_ABOVE_C;
         ST_ABOVE_NR: code = ZONE_ABOVE_NR;
         ST_BELOW_NC: code = ZONE_BELOW_NC;
         ST_BELOW_C:  code = ZONE_BELOW_C;
         ST_BELOW_NR: code = ZONE_BELOW_NR;
         default:     code = ZONE_NORMAL;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/core/threshold_zone_tracker_hysteresis.sv
// ----------------------------------------------------------------------------
// threshold_zone_tracker_hysteresis
// Seven-zone temperature tracker with rising and falling hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample word (sensor number, signed temperature). Only
//   sensor 0 moves the tracker; other sensors get the current zone and last
//   reading back with no event. rsp_* returns exactly one result word per
//   sample: the zone after the sample, an event flag with its code, and the
//   last stored reading.
//   csr_* writes the six thresholds and two offsets; write only while idle.
//   Indexes above seven are ignored.
// Timing:
//   A sample lands in the input register, is evaluated against the zone and
//   reading registers in one pass, and then moves into the result register,
//   which drives rsp_valid and the result word. One sample per cycle is
//   taken back to back while rsp_stall is low, set by the single evaluation
//   stage.
// Reset: zone normal, stored reading 16, all configuration registers 0.
// Stall: while rsp_stall holds a full result register, the input register
//   holds its word and req_stall rises once it is full too.
// ----------------------------------------------------------------------------
module threshold_zone_tracker_hysteresis (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tzt_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tzt_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [tzt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tzt_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // Configuration registers
   logic [7:0] unc_ff, uc_ff, unr_ff, lnc_ff, lc_ff, lnr_ff, rise_ff, fall_ff;

   // Input stage
   logic                     in_valid_ff;
   tzt_pkg::req_payload_type in_word_ff;

   // Tracker state
   tzt_pkg::zone_state_type zone_ff, zone_in;
   logic signed [7:0]       reading_ff, reading_in;

   // Result stage
   logic                     out_valid_ff;
   tzt_pkg::rsp_payload_type out_word_ff, out_word_in;

   logic out_load;
   logic in_load;
   logic tracked;
   logic event_valid;
   logic [3:0] event_code;
   logic [7:0] t;

   // Handshake: result register loads when empty or drained
   assign out_load  = ~out_valid_ff | ~rsp_stall;
   assign req_stall = in_valid_ff & ~out_load;
   assign in_load   = req_valid & ~req_stall;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_word_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unc_ff  <= '0;
         uc_ff   <= '0;
         unr_ff  <= '0;
         lnc_ff  <= '0;
         lc_ff   <= '0;
         lnr_ff  <= '0;
         rise_ff <= '0;
         fall_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tzt_pkg::REG_UPPER_NC:    unc_ff  <= csr_write_data;
            tzt_pkg::REG_UPPER_C:     uc_ff   <= csr_write_data;
            tzt_pkg::REG_UPPER_NR:    unr_ff  <= csr_write_data;
            tzt_pkg::REG_LOWER_NC:    lnc_ff  <= csr_write_data;
            tzt_pkg::REG_LOWER_C:     lc_ff   <= csr_write_data;
            tzt_pkg::REG_LOWER_NR:    lnr_ff  <= csr_write_data;
            tzt_pkg::REG_RISING_OFS:  rise_ff <= csr_write_data;
            tzt_pkg::REG_FALLING_OFS: fall_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Evaluate the held sample against the tracker; return test wins, and in the normal zone the lower test wins
   always_comb begin
      t           = in_word_ff.temperature;
      tracked     = (in_word_ff.sensor_select == 8'd0);
      zone_in     = zone_ff;
      event_code  = tzt_pkg::EV_NONE;
      if (tracked) begin
         case (zone_ff)
            tzt_pkg::ST_NORMAL: begin
               if (tzt_pkg::at_or_above(t, unc_ff, rise_ff)) begin
                  zone_in = tzt_pkg::ST_ABOVE_NC; event_code = tzt_pkg::EV_UNC_HIGH;
               end
               if (tzt_pkg::at_or_below(t, lnc_ff, fall_ff)) begin
                  zone_in = tzt_pkg::ST_BELOW_NC; event_code = tzt_pkg::EV_LNC_LOW;
               end
            end
            tzt_pkg::ST_ABOVE_NC: begin
               if (tzt_pkg::at_or_above(t, uc_ff, rise_ff)) begin
                  zone_in = tzt_pkg::ST_ABOVE_C; event_code = tzt_pkg::EV_UC_HIGH;
               end
               if (tzt_pkg::at_or_below(t, unc_ff, fall_ff)) begin
                  zone_in = tzt_pkg::ST_NORMAL; event_code = tzt_pkg::EV_UNC_LOW;
               end
            end
            tzt_pkg::ST_ABOVE_C: begin
               if (tzt_pkg::at_or_above(t, unr_ff, rise_ff)) begin
                  zone_in = tzt_pkg::ST_ABOVE_NR; event_code = tzt_pkg::EV_UNR_HIGH;
               end
               if (tzt_pkg::at_or_below(t, uc_ff, fall_ff)) begin
                  zone_in = tzt_pkg::ST_ABOVE_NC; event_code = tzt_pkg::EV_UC_LOW;
               end
            end
            tzt_pkg::ST_ABOVE_NR: begin
               if (tzt_pkg::at_or_below(t, unr_ff, fall_ff)) begin
                  zone_in = tzt_pkg::ST_ABOVE_C; event_code = tzt_pkg::EV_UNR_LOW;
               end
            end
            tzt_pkg::ST_BELOW_NC: begin
               if (tzt_pkg::at_or_below(t, lc_ff, fall_ff)) begin
                  zone_in = tzt_pkg::ST_BELOW_C; event_code = tzt_pkg::EV_LC_LOW;
               end
               if (tzt_pkg::at_or_above(t, lnc_ff, rise_ff)) begin
                  zone_in = tzt_pkg::ST_NORMAL; event_code = tzt_pkg::EV_LNC_HIGH;
               end
            end
            tzt_pkg::ST_BELOW_C: begin
               if (tzt_pkg::at_or_below(t, lnr_ff, fall_ff)) begin
                  zone_in = tzt_pkg::ST_BELOW_NR; event_code = tzt_pkg::EV_LNR_LOW;
               end
               if (tzt_pkg::at_or_above(t, lc_ff, rise_ff)) begin
                  zone_in = tzt_pkg::ST_BELOW_NC; event_code = tzt_pkg::EV_LC_HIGH;
               end
            end
            tzt_pkg::ST_BELOW_NR: begin
               if (tzt_pkg::at_or_above(t, lnr_ff, rise_ff)) begin
                  zone_in = tzt_pkg::ST_BELOW_C; event_code = tzt_pkg::EV_LNR_HIGH;
               end
            end
            default: ;
         endcase
      end
      event_valid = (zone_in != zone_ff);
      if (!event_valid) begin
         event_code = tzt_pkg::EV_NONE;
      end
      reading_in = tracked ? $signed(t) : reading_ff;

      out_word_in.zone         = tzt_pkg::zone_code(zone_in);
      out_word_in.event_valid  = event_valid;
      out_word_in.event_code   = event_code;
      out_word_in.last_reading = reading_in;
   end

   // Capture the incoming sample
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_valid_ff == 1'b0 || out_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_word_ff <= req_payload;
      end
   end

   // Advance the tracker as the sample moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff    <= tzt_pkg::ST_NORMAL;
         reading_ff <= tzt_pkg::READING_RESET;
      end else if (in_valid_ff && out_load) begin
         zone_ff    <= zone_in;
         reading_ff <= reading_in;
      end
   end

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff && out_load) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule
